// ===== hw/rtl/vses_pkg.sv =====
package vses_pkg;

    localparam int TICK_COUNT_WIDTH_DEF = 16;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 16;

    localparam logic [2:0] REG_START_V   = 3'd0;
    localparam logic [2:0] REG_STEP_V    = 3'd1;
    localparam logic [2:0] REG_END_V     = 3'd2;
    localparam logic [2:0] REG_STEP_LIM  = 3'd3;
    localparam logic [2:0] REG_SETTLE    = 3'd4;
    localparam logic [2:0] REG_TIMEOUT   = 3'd5;
    localparam logic [2:0] REG_HOLD      = 3'd6;
    localparam logic [2:0] REG_RESTORE_V = 3'd7;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_CLICK = 2'd2;
    localparam logic [1:0] OP_LONG  = 2'd3;

    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_WARMING  = 2'd1;
    localparam logic [1:0] MODE_RUNNING  = 2'd2;
    localparam logic [1:0] MODE_FINISHED = 2'd3;

    localparam logic [1:0] PCMD_NONE    = 2'd0;
    localparam logic [1:0] PCMD_ENABLE  = 2'd1;
    localparam logic [1:0] PCMD_DISABLE = 2'd2;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_STARTED  = 3'd1;
    localparam logic [2:0] EV_KEY      = 3'd2;
    localparam logic [2:0] EV_FAULT    = 3'd3;
    localparam logic [2:0] EV_DISABLED = 3'd4;
    localparam logic [2:0] EV_END      = 3'd5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] output_power;
        logic [15:0] input_power;
        logic        protection_fault;
        logic        supply_enabled;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  test_state;
        logic        setpoint_write;
        logic [12:0] setpoint_value;
        logic [1:0]  power_command;
        logic        fan_forced;
        logic        measure_valid;
        logic [12:0] measured_voltage;
        logic [9:0]  efficiency;
        logic [7:0]  step_number;
        logic        step_skipped;
        logic [2:0]  event_code;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        in_item_t item;
        logic     pow_ok;
    } cmd_t;

endpackage

// ===== hw/rtl/vses_front.sv =====
module vses_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  vses_pkg::in_item_t in_item,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output vses_pkg::cmd_t   cmd
);

    localparam int DEPTH = 2;

    vses_pkg::cmd_t q_reg [DEPTH];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           do_push, do_pop;

    assign full      = (cnt_reg == 2'(DEPTH));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg].item   <= in_item;
            q_reg[wr_ptr_reg].pow_ok <= (in_item.output_power > 16'd10) &&
                                        (in_item.input_power > 16'd10);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ===== hw/rtl/vses_div.sv =====
module vses_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [25:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [25:0] quotient
);

    logic [25:0] q_reg;
    logic [16:0] r_reg;
    logic [15:0] d_reg;
    logic [4:0]  n_reg;
    logic        busy_reg;
    logic [16:0] trial;
    logic [17:0] diff;

    assign trial    = {r_reg[15:0], q_reg[25]};
    assign diff     = {1'b0, trial} - {2'b0, d_reg};
    assign done     = busy_reg && (n_reg == 5'd0);
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= 5'd0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            n_reg    <= 5'd26;
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (busy_reg)
            n_reg <= n_reg - 5'd1;
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg <= dividend;
            r_reg <= 17'd0;
            d_reg <= divisor;
        end
        else if (busy_reg && n_reg != 5'd0)
        begin
            if (!diff[17])
            begin
                r_reg <= diff[16:0];
                q_reg <= {q_reg[24:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[24:0], 1'b0};
            end
        end
    end

endmodule

// ===== hw/rtl/vses_back.sv =====
module vses_back
#(
    parameter int TICK_COUNT_WIDTH = vses_pkg::TICK_COUNT_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  vses_pkg::cmd_t      cmd,
    input  logic [12:0]         start_voltage,
    input  logic [12:0]         step_voltage,
    input  logic [12:0]         end_voltage,
    input  logic [7:0]          step_limit,
    input  logic [15:0]         settle_ticks,
    input  logic [15:0]         timeout_ticks,
    input  logic [15:0]         finish_hold_ticks,
    input  logic [12:0]         restore_voltage,
    output logic                empty,
    input  logic                pop,
    output vses_pkg::out_item_t res
);

    localparam int TW = TICK_COUNT_WIDTH;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};

    typedef enum logic [2:0] {
        S_WAIT = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } bstate_t;

    bstate_t     st_reg;
    logic [1:0]  mode_reg;
    logic [7:0]  step_reg;
    logic [12:0] sp_reg;
    logic [TW-1:0] stc_reg, set_reg, fin_reg;
    vses_pkg::out_item_t res_reg;
    logic        full_reg;
    vses_pkg::cmd_t c_reg;
    logic        div_busy_reg;

    logic        div_go, div_done;
    logic [25:0] div_q;

    vses_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend ({10'd0, c_reg.item.output_power} * 26'd1000),
        .divisor  (c_reg.item.input_power),
        .done     (div_done),
        .quotient (div_q)
    );

    assign empty     = !full_reg;
    assign res       = res_reg;
    assign cmd_ready = (st_reg == S_WAIT) && !full_reg;

    function automatic logic [TW-1:0] sinc(input logic [TW-1:0] v);
        return (v == TMAX) ? TMAX : v + TW'(1);
    endfunction

    // measurement needed?
    logic need_meas;
    assign need_meas = (mode_reg == vses_pkg::MODE_RUNNING) &&
        (c_reg.item.opcode == vses_pkg::OP_TICK) &&
        !c_reg.item.protection_fault && c_reg.item.supply_enabled &&
        !({{(32-TW){1'b0}}, set_reg} < {16'd0, settle_ticks});

    assign div_go = (st_reg == S_DIV) && c_reg.pow_ok && !div_busy_reg;

    logic [9:0] eff;
    assign eff = !c_reg.pow_ok ? 10'd0 :
                 (div_q > 26'd1000) ? 10'd1000 : div_q[9:0];

    logic        ready_exec;
    assign ready_exec = (st_reg == S_OUT);

    // execution combinational
    logic [1:0]  m_n;
    logic [7:0]  sc_n, sc1;
    logic [12:0] sp_n;
    logic [TW-1:0] stc_n, set_n, fin_n, stc_inc;
    vses_pkg::out_item_t o;
    logic [21:0] nv;
    logic [21:0] prod;

    always_comb
    begin
        m_n = mode_reg; sc_n = step_reg; sp_n = sp_reg;
        stc_n = stc_reg; set_n = set_reg; fin_n = fin_reg;
        o = '0;
        sc1 = 8'd0; stc_inc = '0; nv = '0; prod = '0;
        case (c_reg.item.opcode)
            vses_pkg::OP_START:
            begin
                m_n = vses_pkg::MODE_WARMING; sp_n = start_voltage; sc_n = 8'd0;
                stc_n = '0; set_n = '0;
                o.event_code = vses_pkg::EV_STARTED;
            end
            vses_pkg::OP_CLICK:
            begin
                if (mode_reg == vses_pkg::MODE_WARMING)
                begin
                    m_n = vses_pkg::MODE_RUNNING; sc_n = 8'd0; sp_n = start_voltage;
                    stc_n = '0; set_n = '0;
                    o.setpoint_write = 1'b1; o.setpoint_value = start_voltage;
                    o.power_command = vses_pkg::PCMD_ENABLE;
                end
                else if (mode_reg == vses_pkg::MODE_RUNNING)
                begin
                    o.setpoint_write = 1'b1; o.setpoint_value = restore_voltage;
                    o.power_command = vses_pkg::PCMD_DISABLE;
                    m_n = vses_pkg::MODE_IDLE; o.event_code = vses_pkg::EV_KEY;
                end
            end
            vses_pkg::OP_LONG:
            begin
                if (mode_reg == vses_pkg::MODE_WARMING)
                    m_n = vses_pkg::MODE_IDLE;
            end
            default:
            begin
                if (mode_reg == vses_pkg::MODE_RUNNING)
                begin
                    if (c_reg.item.protection_fault || !c_reg.item.supply_enabled)
                    begin
                        o.setpoint_write = 1'b1; o.setpoint_value = restore_voltage;
                        m_n = vses_pkg::MODE_IDLE;
                        o.event_code = c_reg.item.protection_fault ?
                                       vses_pkg::EV_FAULT : vses_pkg::EV_DISABLED;
                    end
                    else
                    begin
                        stc_inc = sinc(stc_reg);
                        stc_n = stc_inc;
                        if (!need_meas)
                            set_n = sinc(set_reg);
                        else
                        begin
                            o.measure_valid = 1'b1; o.measured_voltage = sp_reg;
                            o.efficiency = eff;
                            sc1 = (step_reg < 8'd255) ? step_reg + 8'd1 : step_reg;
                            if ({{(32-TW){1'b0}}, stc_inc} >= {16'd0, timeout_ticks})
                            begin
                                sc1 = (sc1 < 8'd255) ? sc1 + 8'd1 : sc1;
                                stc_n = '0; set_n = '0;
                                o.step_skipped = 1'b1;
                            end
                            sc_n = sc1;
                            prod = {14'd0, sc1} * {9'd0, step_voltage};
                            nv = prod + {9'd0, start_voltage};
                            sp_n = (nv > 22'd8191) ? 13'd8191 : nv[12:0];
                            if (nv > {9'd0, end_voltage} || sc1 >= step_limit)
                            begin
                                o.setpoint_write = 1'b1;
                                o.setpoint_value = restore_voltage;
                                o.power_command = vses_pkg::PCMD_DISABLE;
                                m_n = vses_pkg::MODE_FINISHED;
                                o.event_code = vses_pkg::EV_END;
                            end
                            else
                            begin
                                o.setpoint_write = 1'b1; o.setpoint_value = sp_n;
                                stc_n = '0; set_n = '0;
                            end
                        end
                    end
                end
                else if (mode_reg == vses_pkg::MODE_FINISHED)
                begin
                    fin_n = sinc(fin_reg);
                    if ({{(32-TW){1'b0}}, fin_n} > {16'd0, finish_hold_ticks})
                    begin
                        fin_n = '0; m_n = vses_pkg::MODE_IDLE;
                    end
                end
            end
        endcase
        o.test_state  = m_n;
        o.fan_forced  = (m_n == vses_pkg::MODE_RUNNING);
        o.step_number = sc_n;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
            c_reg <= cmd;
        if (ready_exec)
            res_reg <= o;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0; stc_reg <= '0; set_reg <= '0;
            fin_reg <= '0; step_reg <= '0;
        end
        else if (ready_exec)
        begin
            sp_reg <= sp_n; stc_reg <= stc_n; set_reg <= set_n;
            fin_reg <= fin_n; step_reg <= sc_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_WAIT;
            mode_reg     <= vses_pkg::MODE_IDLE;
            full_reg     <= 1'b0;
            div_busy_reg <= 1'b0;
        end
        else
        begin
            if (pop && full_reg)
                full_reg <= 1'b0;
            case (st_reg)
                S_WAIT:
                    if (cmd_valid && cmd_ready)
                        st_reg <= S_DIV;
                S_DIV:
                begin
                    if (!need_meas || !c_reg.pow_ok)
                        st_reg <= S_OUT;
                    else if (!div_busy_reg)
                        div_busy_reg <= 1'b1;
                    else if (div_done)
                    begin
                        div_busy_reg <= 1'b0;
                        st_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    mode_reg <= m_n;
                    full_reg <= 1'b1;
                    st_reg   <= S_WAIT;
                end
                default:
                    st_reg <= S_WAIT;
            endcase
        end
    end

endmodule

// ===== hw/rtl/vses_cfg.sv =====
module vses_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vses_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [vses_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output logic [12:0]                          start_voltage,
    output logic [12:0]                          step_voltage,
    output logic [12:0]                          end_voltage,
    output logic [7:0]                           step_limit,
    output logic [15:0]                          settle_ticks,
    output logic [15:0]                          timeout_ticks,
    output logic [15:0]                          finish_hold_ticks,
    output logic [12:0]                          restore_voltage
);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_voltage     <= 13'd500;
            step_voltage      <= 13'd25;
            end_voltage       <= 13'd2650;
            step_limit        <= 8'd87;
            settle_ticks      <= 16'd100;
            timeout_ticks     <= 16'd500;
            finish_hold_ticks <= 16'd300;
            restore_voltage   <= 13'd1200;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                vses_pkg::REG_START_V:   start_voltage     <= cfg_data[12:0];
                vses_pkg::REG_STEP_V:    step_voltage      <= cfg_data[12:0];
                vses_pkg::REG_END_V:     end_voltage       <= cfg_data[12:0];
                vses_pkg::REG_STEP_LIM:  step_limit        <= cfg_data[7:0];
                vses_pkg::REG_SETTLE:    settle_ticks      <= cfg_data;
                vses_pkg::REG_TIMEOUT:   timeout_ticks     <= cfg_data;
                vses_pkg::REG_HOLD:      finish_hold_ticks <= cfg_data;
                vses_pkg::REG_RESTORE_V: restore_voltage   <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/voltage_sweep_efficiency_sequencer.sv =====
// Power-supply efficiency sweep sequencer.
// Input channel: push/full carries one event (tick, start, click, long press)
// with the measured powers and supply status; a transfer happens when push is
// high and full is low. A two-entry queue sits between the front end and the
// sequencer, so up to two events can be taken while the sequencer is busy.
// Result channel: one result per event, shown while empty is low and taken
// when pop is high. A waiting result stalls the sequencer only; the input
// queue keeps filling until full.
// Each event passes the wait, divide and output states; a tick that measures
// efficiency stays in the divide state for the 26-step serial divider for
// Pout*1000/Pin. A new event is taken only once the last result is popped.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while idle.
// Reset: sequencer idle, counters cleared, registers at their defaults.
module voltage_sweep_efficiency_sequencer
#(
    parameter int TICK_COUNT_WIDTH = vses_pkg::TICK_COUNT_WIDTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  vses_pkg::in_item_t                   in_item,
    output logic                                 empty,
    input  logic                                 pop,
    output vses_pkg::out_item_t                  out_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vses_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [vses_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic [12:0] start_voltage, step_voltage, end_voltage, restore_voltage;
    logic [7:0]  step_limit;
    logic [15:0] settle_ticks, timeout_ticks, finish_hold_ticks;
    logic        cmd_valid, cmd_ready;
    vses_pkg::cmd_t cmd;

    vses_cfg u_cfg
    (
        .clk (clk), .rst_n (rst_n),
        .cfg_valid (cfg_valid), .cfg_ready (cfg_ready),
        .cfg_index (cfg_index), .cfg_data (cfg_data),
        .start_voltage (start_voltage), .step_voltage (step_voltage),
        .end_voltage (end_voltage), .step_limit (step_limit),
        .settle_ticks (settle_ticks), .timeout_ticks (timeout_ticks),
        .finish_hold_ticks (finish_hold_ticks), .restore_voltage (restore_voltage)
    );

    vses_front u_front
    (
        .clk (clk), .rst_n (rst_n),
        .push (push), .full (full), .in_item (in_item),
        .cmd_valid (cmd_valid), .cmd_ready (cmd_ready), .cmd (cmd)
    );

    vses_back #(.TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)) u_back
    (
        .clk (clk), .rst_n (rst_n),
        .cmd_valid (cmd_valid), .cmd_ready (cmd_ready), .cmd (cmd),
        .start_voltage (start_voltage), .step_voltage (step_voltage),
        .end_voltage (end_voltage), .step_limit (step_limit),
        .settle_ticks (settle_ticks), .timeout_ticks (timeout_ticks),
        .finish_hold_ticks (finish_hold_ticks), .restore_voltage (restore_voltage),
        .empty (empty), .pop (pop), .res (out_item)
    );

endmodule
